// ===== design/shortest_remaining_time_scheduler_unit_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Included by srts_dp, the module that checks its own logic; depends on nothing.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/srts_pkg.sv =====
// Shared constants and controller/datapath interface types for the scheduler.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package srts_pkg;

   localparam int MAX_JOBS    = 16;
   localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W       = $clog2(MAX_JOBS + 1);
   localparam int TIME_W      = 16;
   localparam int TICK_W      = 24;
   localparam int TOTAL_W     = 30;
   localparam int JOB_INDEX_W = 6;

   localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam int REQ_TDATA_W = 2 * TIME_W;
   localparam int RSP_FIELD_W = JOB_INDEX_W + 3 * TICK_W + 2 * TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;        // store the accepted job
      logic scan_start;  // clear the scan registers and index
      logic scan;        // examine one job table entry
      logic step;        // apply the scan result to time and the table
      logic emit_start;  // clear the output index and totals
      logic emit;        // load one result into the output register
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic all_done;    // every stored job has finished
      logic scan_last;   // the scan index sits on the last stored job
      logic emit_last;   // the output index sits on the last stored job
      logic out_free;    // the output register can take a result
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/shortest_remaining_time_scheduler_unit.sv =====
// Top level of the shortest-remaining-time-first scheduler: ports and tdata packing.
// Depends on srts_pkg, srts_ctrl and srts_dp.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: arrival, burst; tlast: last job
//   rsp      out        rsp_tvalid/tready     tdata: per-job times, totals; tlast: last
//
// Loading takes one job per cycle. After the last job the scheduler runs a
// scan/step loop: each scheduling event scans every stored job and then steps,
// with at most 2 * job_count events. Results then leave at one per cycle while
// rsp is not stalled. Reset is synchronous and needs no clearing pass. A stalled
// rsp holds its result; the next job set may load while the final result waits.
`timescale 1ns / 1ps
`default_nettype none

module shortest_remaining_time_scheduler_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // arrival_time [15:0], burst_length [31:16]
   input  wire logic [srts_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             req_tlast,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // job_index [5:0], completion_time [29:6], turnaround_time [53:30],
   // waiting_time [77:54], total_turnaround [107:78], total_waiting [137:108],
   // zero fill above
   output logic [srts_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready
);
   import srts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic [JOB_INDEX_W-1:0] job_index;
   logic [TICK_W-1:0]      completion_time, turnaround_time, waiting_time;
   logic [TOTAL_W-1:0]     total_turnaround, total_waiting;

   srts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .arrival_time     (req_tdata[TIME_W-1:0]),
      .burst_length     (req_tdata[2*TIME_W-1:TIME_W]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .job_index        (job_index),
      .completion_time  (completion_time),
      .turnaround_time  (turnaround_time),
      .waiting_time     (waiting_time),
      .total_turnaround (total_turnaround),
      .total_waiting    (total_waiting),
      .last_result      (rsp_tlast)
   );

   // Pack result fields, lowest field first
   assign rsp_tdata = RSP_TDATA_W'({total_waiting, total_turnaround, waiting_time,
                                    turnaround_time, completion_time, job_index});

endmodule

`default_nettype wire

// ===== design/srts_ctrl.sv =====
// Sequencer for the scheduler: load, scan/step loop, result emission.
// Depends on srts_pkg; drives the datapath srts_dp through command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module srts_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tlast,
   output logic                        req_tready,
   input  wire srts_pkg::dp_status_type status,
   output srts_pkg::ctrl_cmd_type      cmd
);
   import srts_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Decode commands and next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.all_done) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/srts_dp.sv =====
// Datapath of the scheduler: job table, scan unit, time step and result register.
// Depends on srts_pkg and the assertion macros; sequenced by srts_ctrl.
`timescale 1ns / 1ps
`default_nettype none

`include "shortest_remaining_time_scheduler_unit_macros.svh"

module srts_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire srts_pkg::ctrl_cmd_type            cmd,
   output srts_pkg::dp_status_type                status,
   input  wire logic [srts_pkg::TIME_W-1:0]       arrival_time,
   input  wire logic [srts_pkg::TIME_W-1:0]       burst_length,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [srts_pkg::JOB_INDEX_W-1:0]       job_index,
   output logic [srts_pkg::TICK_W-1:0]            completion_time,
   output logic [srts_pkg::TICK_W-1:0]            turnaround_time,
   output logic [srts_pkg::TICK_W-1:0]            waiting_time,
   output logic [srts_pkg::TOTAL_W-1:0]           total_turnaround,
   output logic [srts_pkg::TOTAL_W-1:0]           total_waiting,
   output logic                                   last_result
);
   import srts_pkg::*;

   // Job table
   logic [TIME_W-1:0] arr_mem [MAX_JOBS];
   logic [TIME_W-1:0] bur_mem [MAX_JOBS];
   logic [TIME_W-1:0] rem_mem [MAX_JOBS];
   logic [TICK_W-1:0] cmp_mem [MAX_JOBS];

   // Counters and time
   logic [CNT_W-1:0]  job_cnt_ff, job_cnt_in;
   logic [CNT_W-1:0]  fin_cnt_ff, fin_cnt_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Scan results
   logic              best_found_ff, best_found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_rem_ff, best_rem_in;
   logic              next_found_ff, next_found_in;
   logic [TIME_W-1:0] next_arr_ff, next_arr_in;

   // Running totals and output register
   logic [TOTAL_W-1:0]     tot_tat_ff, tot_tat_in;
   logic [TOTAL_W-1:0]     tot_wt_ff, tot_wt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [JOB_INDEX_W-1:0] job_index_ff;
   logic [TICK_W-1:0]      completion_ff, turnaround_ff, waiting_ff;
   logic [TOTAL_W-1:0]     total_tat_ff, total_wt_ff;
   logic                   last_ff;

   logic [CNT_W-1:0]  idx_plus_one;
   logic              table_full;
   logic [IDX_W-1:0]  load_idx;

   logic [TIME_W-1:0] e_rem, e_arr;
   logic              e_arrived, take_best, take_next;

   logic [TICK_W-1:0] gap;
   logic [TIME_W-1:0] run;
   logic [TICK_W:0]   run_sum;
   logic [TICK_W-1:0] run_tick;
   logic [TIME_W-1:0] new_rem;

   logic [TICK_W-1:0]  o_ct, o_arr, o_bur, o_tat, o_wt;
   logic [TOTAL_W:0]   tat_sum, wt_sum;
   logic [TOTAL_W-1:0] tat_sat, wt_sat;

   assign idx_plus_one = CNT_W'(idx_ff) + CNT_W'(1);
   assign table_full   = (job_cnt_ff >= CNT_W'(MAX_JOBS));
   assign load_idx     = job_cnt_ff[IDX_W-1:0];

   // Examine one table entry against the current tick
   assign e_rem     = rem_mem[idx_ff];
   assign e_arr     = arr_mem[idx_ff];
   assign e_arrived = (TICK_W'(e_arr) <= tick_ff);
   assign take_best = (e_rem != '0) && e_arrived && (!best_found_ff || (e_rem < best_rem_ff));
   assign take_next = (e_rem != '0) && !e_arrived &&
                      (!next_found_ff || (e_arr < next_arr_ff));

   // Run the chosen job until it finishes or the next arrival, saturate time
   assign gap      = TICK_W'(next_arr_ff) - tick_ff;
   assign run      = (next_found_ff && (gap < TICK_W'(best_rem_ff))) ?
                     gap[TIME_W-1:0] : best_rem_ff;
   assign run_sum  = {1'b0, tick_ff} + (TICK_W+1)'(run);
   assign run_tick = run_sum[TICK_W] ? TICK_MAX : run_sum[TICK_W-1:0];
   assign new_rem  = best_rem_ff - run;

   // Form one result, floor the differences, saturate the totals
   assign o_ct    = cmp_mem[idx_ff];
   assign o_arr   = TICK_W'(arr_mem[idx_ff]);
   assign o_bur   = TICK_W'(bur_mem[idx_ff]);
   assign o_tat   = (o_ct >= o_arr) ? (o_ct - o_arr) : '0;
   assign o_wt    = (o_tat >= o_bur) ? (o_tat - o_bur) : '0;
   assign tat_sum = (TOTAL_W+1)'(tot_tat_ff) + (TOTAL_W+1)'(o_tat);
   assign wt_sum  = (TOTAL_W+1)'(tot_wt_ff) + (TOTAL_W+1)'(o_wt);
   assign tat_sat = tat_sum[TOTAL_W] ? TOTAL_MAX : tat_sum[TOTAL_W-1:0];
   assign wt_sat  = wt_sum[TOTAL_W] ? TOTAL_MAX : wt_sum[TOTAL_W-1:0];

   assign status.all_done  = (fin_cnt_ff == job_cnt_ff);
   assign status.scan_last = (idx_plus_one == job_cnt_ff);
   assign status.emit_last = (idx_plus_one == job_cnt_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Next values of counters, scan registers and totals
   always_comb begin
      job_cnt_in    = job_cnt_ff;
      fin_cnt_in    = fin_cnt_ff;
      tick_in       = tick_ff;
      idx_in        = idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_rem_in   = best_rem_ff;
      next_found_in = next_found_ff;
      next_arr_in   = next_arr_ff;
      tot_tat_in    = tot_tat_ff;
      tot_wt_in     = tot_wt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.load && !table_full) begin
         job_cnt_in = job_cnt_ff + CNT_W'(1);
         if (burst_length == '0) begin
            fin_cnt_in = fin_cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.scan_start || cmd.emit_start) begin
         idx_in        = '0;
         best_found_in = 1'b0;
         next_found_in = 1'b0;
         tot_tat_in    = '0;
         tot_wt_in     = '0;
      end

      if (cmd.scan) begin
         idx_in = idx_ff + IDX_W'(1);
         if (take_best) begin
            best_found_in = 1'b1;
            best_idx_in   = idx_ff;
            best_rem_in   = e_rem;
         end
         if (take_next) begin
            next_found_in = 1'b1;
            next_arr_in   = e_arr;
         end
      end

      if (cmd.step) begin
         if (best_found_ff) begin
            tick_in = run_tick;
            if (new_rem == '0) begin
               fin_cnt_in = fin_cnt_ff + CNT_W'(1);
            end
         end else begin
            tick_in = TICK_W'(next_arr_ff);
         end
      end

      if (cmd.emit) begin
         idx_in       = idx_ff + IDX_W'(1);
         tot_tat_in   = tat_sat;
         tot_wt_in    = wt_sat;
         rsp_valid_in = 1'b1;
         // return to empty after the final result
         if (status.emit_last) begin
            job_cnt_in = '0;
            fin_cnt_in = '0;
            tick_in    = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_cnt_ff    <= '0;
         fin_cnt_ff    <= '0;
         tick_ff       <= '0;
         idx_ff        <= '0;
         best_found_ff <= 1'b0;
         next_found_ff <= 1'b0;
         tot_tat_ff    <= '0;
         tot_wt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_cnt_ff    <= job_cnt_in;
         fin_cnt_ff    <= fin_cnt_in;
         tick_ff       <= tick_in;
         idx_ff        <= idx_in;
         best_found_ff <= best_found_in;
         next_found_ff <= next_found_in;
         tot_tat_ff    <= tot_tat_in;
         tot_wt_ff     <= tot_wt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      next_arr_ff <= next_arr_in;
      if (cmd.emit) begin
         job_index_ff  <= JOB_INDEX_W'(idx_ff);
         completion_ff <= o_ct;
         turnaround_ff <= o_tat;
         waiting_ff    <= o_wt;
         total_tat_ff  <= status.emit_last ? tat_sat : '0;
         total_wt_ff   <= status.emit_last ? wt_sat : '0;
         last_ff       <= status.emit_last;
      end
   end

   // Write the job table: load a job, or retire service time
   always_ff @(posedge clock) begin
      if (cmd.load && !table_full) begin
         arr_mem[load_idx] <= arrival_time;
         bur_mem[load_idx] <= burst_length;
         rem_mem[load_idx] <= burst_length;
         if (burst_length == '0) begin
            cmp_mem[load_idx] <= TICK_W'(arrival_time);
         end
      end else if (cmd.step && best_found_ff) begin
         rem_mem[best_idx_ff] <= new_rem;
         if (new_rem == '0) begin
            cmp_mem[best_idx_ff] <= run_tick;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign job_index        = job_index_ff;
   assign completion_time  = completion_ff;
   assign turnaround_time  = turnaround_ff;
   assign waiting_time     = waiting_ff;
   assign total_turnaround = total_tat_ff;
   assign total_waiting    = total_wt_ff;
   assign last_result      = last_ff;

   `SRTS_ASSERT_NOW(a_fin_le_jobs, clock, reset, 1'b1, fin_cnt_ff <= job_cnt_ff, "finished count above job count")
   `SRTS_ASSERT_NOW(a_jobs_bounded, clock, reset, 1'b1, job_cnt_ff <= CNT_W'(MAX_JOBS), "job count above table size")
   `SRTS_ASSERT_NOW(a_idle_has_arrival, clock, reset, cmd.step && !best_found_ff, next_found_ff, "idle step without a pending arrival")
   `SRTS_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not presented")

endmodule

`default_nettype wire
